[rtl/fmc_pkg.sv]
// ----------------------------------------------------------------------------
// fmc_pkg
// Types, codes and helpers shared by the mutex and condition variable unit.
// ----------------------------------------------------------------------------
package fmc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QD_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_W = 3;
  localparam int FIB_W  = 4;
  localparam int SCH_W  = 2;
  localparam int STAT_W = 3;

  localparam logic [MODE_W-1:0] MODE_LOCK      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNLOCK    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNLOCK_IF = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WAIT      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SIGNAL    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BCAST     = 3'd5;

  localparam logic [STAT_W-1:0] STAT_GRANTED      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_QUEUED       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DONE         = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_RELEASED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ALREADY_OWN  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_OWNER    = 3'd5;
  localparam logic [STAT_W-1:0] STAT_FULL         = 3'd6;

  typedef struct packed {
    logic [FIB_W-1:0] fib;
    logic [SCH_W-1:0] sch;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FIB_W-1:0]  requester;
    logic [SCH_W-1:0]  sched_id;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              wake_valid;
    logic [FIB_W-1:0]  wake_fiber;
    logic [SCH_W-1:0]  wake_sched;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_COMMIT,
    S_REPLY
  } state_t;

  // ring slot: base < depth, off <= depth
  function automatic logic [QD_W-1:0] slot_add(logic [QD_W-1:0] base, logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - QD_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[QD_W-1:0];
  endfunction

endpackage

[rtl/fmc_ram.sv]
// ----------------------------------------------------------------------------
// fmc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fmc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/fifo_mutex_with_condition.sv]
// ----------------------------------------------------------------------------
// fifo_mutex_with_condition
// One mutex with a FIFO hand-off queue and one condition variable queue.
// ----------------------------------------------------------------------------
// One request at a time. For lock, unlock, condition wait and signal, the
// accept cycle issues the queue RAM reads at the head pointers and the
// next cycle decides and writes back. Broadcast over n condition waiters
// makes one pass over the condition RAM to check ownership and room, then
// one pass moving entries into the mutex queue RAM, one entry per cycle.
// A result that cannot leave because the output holds an unread one waits
// in a reply state until it is taken. Queue RAMs need no clearing after reset.
module fifo_mutex_with_condition (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fmc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fmc_pkg::rsp_t rsp
);

  import fmc_pkg::*;

  state_t            state, state_next;
  logic              owner_held, owner_held_next;
  logic [FIB_W-1:0]  owner_fiber, owner_fiber_next;
  logic [QD_W-1:0]   lhead, lhead_next;
  logic [CNT_W-1:0]  lcount, lcount_next;
  logic [QD_W-1:0]   chead, chead_next;
  logic [CNT_W-1:0]  ccount, ccount_next;
  req_t              cur;
  logic [QD_W-1:0]   idx, idx_next;
  logic [FIB_W-1:0]  own_ref, own_ref_next;
  logic              scan_bad, scan_bad_next;
  rsp_t              res, res_next;
  rsp_t              out;
  logic              out_valid, out_valid_next;

  logic              fin;
  rsp_t              fin_rsp;
  logic              slot_free;

  logic              l_we, c_we;
  logic [QD_W-1:0]   l_waddr, c_waddr, c_raddr;
  entry_t            l_wdata, c_wdata, lrd, crd;

  logic              is_owner, lock_full, cond_full, last, bad_now;
  logic [CNT_W-1:0]  moved;
  logic [CNT_W:0]    room_sum;

  fmc_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_lock_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (lhead),
    .rdata (lrd)
  );

  fmc_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_cond_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (crd)
  );

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;
  assign rsp       = out;
  assign slot_free = !out_valid || rsp_ready;

  assign is_owner  = owner_held && (owner_fiber == cur.requester);
  assign lock_full = (lcount == CNT_W'(QUEUE_DEPTH));
  assign cond_full = (ccount == CNT_W'(QUEUE_DEPTH));
  assign last      = (CNT_W'(idx) == ccount - CNT_W'(1));
  assign bad_now   = (owner_held || idx != '0) && (crd.fib == own_ref);
  assign moved     = owner_held ? ccount : ccount - CNT_W'(1);
  assign room_sum  = {1'b0, lcount} + {1'b0, moved};

  always_comb begin
    state_next       = state;
    owner_held_next  = owner_held;
    owner_fiber_next = owner_fiber;
    lhead_next       = lhead;
    lcount_next      = lcount;
    chead_next       = chead;
    ccount_next      = ccount;
    idx_next         = idx;
    own_ref_next     = own_ref;
    scan_bad_next    = scan_bad;
    res_next         = res;
    fin              = 1'b0;
    fin_rsp          = '{status: STAT_DONE, wake_valid: 1'b0, wake_fiber: '0, wake_sched: '0};
    l_we             = 1'b0;
    l_waddr          = slot_add(lhead, lcount);
    l_wdata          = '{fib: cur.requester, sch: cur.sched_id};
    c_we             = 1'b0;
    c_waddr          = slot_add(chead, ccount);
    c_wdata          = '{fib: cur.requester, sch: cur.sched_id};
    c_raddr          = chead;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        fin = 1'b1;
        case (cur.mode)
          MODE_LOCK: begin
            if (is_owner) begin
              fin_rsp.status = STAT_ALREADY_OWN;
            end else if (!owner_held) begin
              owner_held_next  = 1'b1;
              owner_fiber_next = cur.requester;
              fin_rsp.status   = STAT_GRANTED;
            end else if (lock_full) begin
              fin_rsp.status = STAT_FULL;
            end else begin
              l_we           = 1'b1;
              lcount_next    = lcount + CNT_W'(1);
              fin_rsp.status = STAT_QUEUED;
            end
          end
          MODE_UNLOCK, MODE_UNLOCK_IF, MODE_WAIT: begin
            if (!is_owner) begin
              fin_rsp.status = STAT_NOT_OWNER;
            end else if (cur.mode == MODE_UNLOCK_IF && lcount == '0) begin
              fin_rsp.status = STAT_NOT_RELEASED;
            end else if (cur.mode == MODE_WAIT && cond_full) begin
              fin_rsp.status = STAT_FULL;
            end else begin
              if (cur.mode == MODE_WAIT) begin
                c_we           = 1'b1;
                ccount_next    = ccount + CNT_W'(1);
                fin_rsp.status = STAT_QUEUED;
              end
              // release, handing off to the oldest mutex waiter
              if (lcount != '0) begin
                owner_fiber_next   = lrd.fib;
                lhead_next         = slot_add(lhead, CNT_W'(1));
                lcount_next        = lcount - CNT_W'(1);
                fin_rsp.wake_valid = 1'b1;
                fin_rsp.wake_fiber = lrd.fib;
                fin_rsp.wake_sched = lrd.sch;
              end else begin
                owner_held_next = 1'b0;
              end
            end
          end
          MODE_SIGNAL: begin
            if (ccount != '0) begin
              if (owner_held && owner_fiber == crd.fib) begin
                fin_rsp.status = STAT_ALREADY_OWN;
              end else if (!owner_held) begin
                owner_held_next    = 1'b1;
                owner_fiber_next   = crd.fib;
                chead_next         = slot_add(chead, CNT_W'(1));
                ccount_next        = ccount - CNT_W'(1);
                fin_rsp.wake_valid = 1'b1;
                fin_rsp.wake_fiber = crd.fib;
                fin_rsp.wake_sched = crd.sch;
              end else if (lock_full) begin
                fin_rsp.status = STAT_FULL;
              end else begin
                l_we        = 1'b1;
                l_wdata     = crd;
                lcount_next = lcount + CNT_W'(1);
                chead_next  = slot_add(chead, CNT_W'(1));
                ccount_next = ccount - CNT_W'(1);
              end
            end
          end
          MODE_BCAST: begin
            if (ccount != '0) begin
              fin           = 1'b0;
              state_next    = S_SCAN;
              idx_next      = '0;
              scan_bad_next = 1'b0;
              own_ref_next  = owner_fiber;
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        c_raddr       = last ? chead : slot_add(chead, CNT_W'(idx) + CNT_W'(1));
        scan_bad_next = scan_bad || bad_now;
        if (idx == '0 && !owner_held) begin
          own_ref_next = crd.fib;
        end
        if (last) begin
          if (scan_bad || bad_now) begin
            fin            = 1'b1;
            fin_rsp.status = STAT_ALREADY_OWN;
          end else if (room_sum > (CNT_W + 1)'(QUEUE_DEPTH)) begin
            fin            = 1'b1;
            fin_rsp.status = STAT_FULL;
          end else begin
            state_next = S_COMMIT;
            idx_next   = '0;
            res_next   = '{status: STAT_DONE, wake_valid: 1'b0, wake_fiber: '0, wake_sched: '0};
          end
        end else begin
          idx_next = idx + QD_W'(1);
        end
      end

      S_COMMIT: begin
        c_raddr = slot_add(chead, CNT_W'(idx) + CNT_W'(1));
        if (idx == '0 && !owner_held) begin
          owner_held_next     = 1'b1;
          owner_fiber_next    = crd.fib;
          res_next.wake_valid = 1'b1;
          res_next.wake_fiber = crd.fib;
          res_next.wake_sched = crd.sch;
        end else begin
          l_we        = 1'b1;
          l_wdata     = crd;
          lcount_next = lcount + CNT_W'(1);
        end
        if (last) begin
          fin         = 1'b1;
          fin_rsp     = res_next;
          chead_next  = slot_add(chead, ccount);
          ccount_next = '0;
        end else begin
          idx_next = idx + QD_W'(1);
        end
      end

      S_REPLY: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      res_next   = fin_rsp;
      state_next = slot_free ? S_IDLE : S_REPLY;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if ((fin || state == S_REPLY) && slot_free) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      owner_held  <= 1'b0;
      owner_fiber <= '0;
      lhead       <= '0;
      lcount      <= '0;
      chead       <= '0;
      ccount      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      owner_held  <= owner_held_next;
      owner_fiber <= owner_fiber_next;
      lhead       <= lhead_next;
      lcount      <= lcount_next;
      chead       <= chead_next;
      ccount      <= ccount_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur <= req;
    end
    idx      <= idx_next;
    own_ref  <= own_ref_next;
    scan_bad <= scan_bad_next;
    res      <= res_next;
    if ((fin || state == S_REPLY) && slot_free) begin
      out <= fin ? fin_rsp : res;
    end
  end

endmodule

[rtl/fmc_checker.sv]
// ----------------------------------------------------------------------------
// fmc_checker
// Port-level checks on the mutex and condition variable unit.
// ----------------------------------------------------------------------------
module fmc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input fmc_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input fmc_pkg::rsp_t rsp
);

  import fmc_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_wake_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.wake_valid |-> rsp.status == STAT_DONE || rsp.status == STAT_QUEUED)
    else $error("wake reported with a status that hands nothing over");

  a_wake_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.wake_valid |-> rsp.wake_fiber == '0 && rsp.wake_sched == '0)
    else $error("wake fields set without a wake");

endmodule

bind fifo_mutex_with_condition fmc_checker u_fmc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
